[rtl/core/sharpen_3x3_rgb_filter_defines.svh]
// Assertion macros shared by the sharpening filter RTL.
`ifndef SHARPEN_3X3_RGB_FILTER_DEFINES_SVH
`define SHARPEN_3X3_RGB_FILTER_DEFINES_SVH

// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define SHRP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// cond must never hold at a clock edge outside reset.
`define SHRP_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

[rtl/core/shrp_pkg.sv]
// Types and fixed constants of the 3x3 RGB sharpening filter.
package shrp_pkg;

   localparam int RGB_W     = 8;
   localparam int DIM_W     = 11;
   localparam int POS_W     = 10;
   localparam int WIN_N     = 9;
   localparam int CENTRE    = 4;
   localparam int NSUM_W    = 11;   // eight neighbours of 8 bits
   localparam int CEN9_W    = 12;   // nine times an 8 bit centre
   localparam int DIFF_W    = 13;
   localparam int PIX_MAX   = 255;
   localparam int DIM_MIN   = 3;
   localparam int DIM_RESET = 512;

   // Queue between front and back, and the result queue.
   localparam int JOB_DEPTH = 4;
   localparam int RSP_DEPTH = 4;
   localparam int LVL_W     = 3;    // holds 0..4

   typedef struct packed {
      logic [RGB_W-1:0] red;
      logic [RGB_W-1:0] green;
      logic [RGB_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [RGB_W-1:0] pix_red;
      logic [RGB_W-1:0] pix_green;
      logic [RGB_W-1:0] pix_blue;
      logic             frame_start;
   } req_type;

   typedef struct packed {
      logic [RGB_W-1:0] sharp_red;
      logic [RGB_W-1:0] sharp_green;
      logic [RGB_W-1:0] sharp_blue;
      logic [POS_W-1:0] out_row;
      logic [POS_W-1:0] out_col;
      logic             frame_done;
   } rsp_type;

   // One complete neighbourhood, raster order, centre at index 4.
   typedef struct packed {
      rgb_type [WIN_N-1:0] win;
      logic [POS_W-1:0]    row;
      logic [POS_W-1:0]    col;
      logic                done;
   } job_type;

endpackage

[rtl/core/shrp_fifo.sv]
// Small register queue with occupancy count.
`include "sharpen_3x3_rgb_filter_defines.svh"

module shrp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_push,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_pop,
   output logic [WIDTH-1:0]           rd_data,
   output logic                       rd_empty,
   output logic [$clog2(DEPTH+1)-1:0] level
);
   localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW  = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0]    level_ff, level_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (wr_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (rd_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (wr_push && !rd_pop) begin
         level_in = level_ff + LW'(1);
      end else if (rd_pop && !wr_push) begin
         level_in = level_ff - LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data  = slot_ff[rd_ptr_ff];
   assign rd_empty = (level_ff == '0);
   assign level    = level_ff;

   `SHRP_ASSERT_NEVER(a_no_overflow, clock, reset, wr_push && !rd_pop && level_ff == LW'(DEPTH), "queue overflow")
   `SHRP_ASSERT_NEVER(a_no_underflow, clock, reset, rd_pop && level_ff == '0, "queue underflow")

endmodule

[rtl/core/shrp_front.sv]
// Front end: position counters, line stores, 3x3 window and job issue.
`include "sharpen_3x3_rgb_filter_defines.svh"

module shrp_front #(
   parameter int MAX_DIM = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  shrp_pkg::req_type             req_item,
   input  logic [shrp_pkg::DIM_W-1:0]    image_dim,
   input  logic [shrp_pkg::LVL_W-1:0]    job_level,
   output logic                          job_push,
   output shrp_pkg::job_type             job_data
);
   import shrp_pkg::*;

   localparam int CW    = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 2;
   localparam int EXT_W = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
   localparam int CMP_W = EXT_W + 1;
   localparam int RX_W  = (CW > POS_W) ? CW : POS_W;
   localparam int LW_W  = 2 * RGB_W * 3;   // upper and middle pixel

   logic             accept;
   logic [CW-1:0]    row_ff, row_in, col_ff, col_in;
   logic [CW-1:0]    r_cur, c_cur;
   logic [CMP_W-1:0] dim_eff, dim_raw, r_ext, c_ext;
   logic             interior, last_pix;

   // line store word: [47:24] row above the middle one, [23:0] middle row
   logic [LW_W-1:0]  line_mem [MAX_DIM];
   logic [LW_W-1:0]  rd_ff, fwd_data_ff, line_word, wr_word;
   logic             fwd_ff;

   logic             s1_valid_ff, s1_int_ff, s1_done_ff;
   rgb_type          s1_px_ff, px_cur, top_pix, mid_pix;
   logic [CW-1:0]    s1_addr_ff;
   logic [POS_W-1:0] s1_row_ff, s1_col_ff;
   rgb_type          win_ff [6];

   assign accept = push && !full;
   assign full   = ({1'b0, job_level} + (LVL_W + 1)'(s1_valid_ff))
                   >= (LVL_W + 1)'(JOB_DEPTH);

   always_comb begin
      px_cur  = '{red: req_item.pix_red, green: req_item.pix_green,
                  blue: req_item.pix_blue};
      r_cur   = req_item.frame_start ? '0 : row_ff;
      c_cur   = req_item.frame_start ? '0 : col_ff;
      dim_raw = CMP_W'(image_dim);
      if (dim_raw < CMP_W'(DIM_MIN)) begin
         dim_eff = CMP_W'(DIM_MIN);
      end else if (dim_raw > CMP_W'(MAX_DIM)) begin
         dim_eff = CMP_W'(MAX_DIM);
      end else begin
         dim_eff = dim_raw;
      end
      r_ext    = CMP_W'(r_cur);
      c_ext    = CMP_W'(c_cur);
      interior = (r_ext >= CMP_W'(2)) && (c_ext >= CMP_W'(2))
                 && (r_ext < dim_eff) && (c_ext < dim_eff);
      last_pix = (r_ext + CMP_W'(1) == dim_eff) && (c_ext + CMP_W'(1) == dim_eff);
      if (c_ext + CMP_W'(1) >= dim_eff) begin
         col_in = '0;
         row_in = (r_ext + CMP_W'(1) >= dim_eff) ? '0 : r_cur + CW'(1);
      end else begin
         col_in = c_cur + CW'(1);
         row_in = r_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
      end
   end

   // stage 1 payload, captured with the line store read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff    <= px_cur;
         s1_addr_ff  <= c_cur;
         s1_int_ff   <= interior;
         s1_done_ff  <= last_pix;
         s1_row_ff   <= POS_W'(RX_W'(r_cur) - RX_W'(1));
         s1_col_ff   <= POS_W'(RX_W'(c_cur) - RX_W'(1));
         // same column written back this edge: the read sees the old word
         fwd_ff      <= s1_valid_ff && (s1_addr_ff == c_cur);
         fwd_data_ff <= wr_word;
      end
   end

   always_comb begin
      line_word = fwd_ff ? fwd_data_ff : rd_ff;
      top_pix   = line_word[LW_W-1:LW_W/2];
      mid_pix   = line_word[LW_W/2-1:0];
      wr_word   = {mid_pix, s1_px_ff};
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[c_cur];
      end
      if (s1_valid_ff) begin
         line_mem[s1_addr_ff] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= top_pix;
         win_ff[2] <= win_ff[3];
         win_ff[3] <= mid_pix;
         win_ff[4] <= win_ff[5];
         win_ff[5] <= s1_px_ff;
      end
   end

   always_comb begin
      job_push        = s1_valid_ff && s1_int_ff;
      job_data.win[0] = win_ff[0];
      job_data.win[1] = win_ff[1];
      job_data.win[2] = top_pix;
      job_data.win[3] = win_ff[2];
      job_data.win[4] = win_ff[3];
      job_data.win[5] = mid_pix;
      job_data.win[6] = win_ff[4];
      job_data.win[7] = win_ff[5];
      job_data.win[8] = s1_px_ff;
      job_data.row    = s1_row_ff;
      job_data.col    = s1_col_ff;
      job_data.done   = s1_done_ff;
   end

   `SHRP_ASSERT_IMPLY(a_job_credit, clock, reset, job_push, job_level < LVL_W'(JOB_DEPTH), "job issued into a full queue")

endmodule

[rtl/core/shrp_back.sv]
// Back end: per-channel sharpening sums, clamp and result issue.
`include "sharpen_3x3_rgb_filter_defines.svh"

module shrp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_empty,
   input  shrp_pkg::job_type          job_data,
   output logic                       job_pop,
   input  logic [shrp_pkg::LVL_W-1:0] rsp_level,
   output logic                       rsp_push,
   output shrp_pkg::rsp_type          rsp_data
);
   import shrp_pkg::*;

   logic              b1_valid_ff;
   logic [CEN9_W-1:0] cen9_ff [3], cen9_in [3];
   logic [NSUM_W-1:0] nsum_ff [3], nsum_in [3];
   logic [POS_W-1:0]  b1_row_ff, b1_col_ff;
   logic              b1_done_ff;
   logic [RGB_W-1:0]  sharp [3];

   function automatic logic [RGB_W-1:0] chan_of(rgb_type px, int k);
      logic [RGB_W-1:0] v;
      case (k)
         0:       v = px.red;
         1:       v = px.green;
         default: v = px.blue;
      endcase
      return v;
   endfunction

   function automatic logic [RGB_W-1:0] clamp(logic [CEN9_W-1:0] cen9,
                                              logic [NSUM_W-1:0] nsum);
      logic signed [DIFF_W-1:0] diff;
      logic [RGB_W-1:0]         res;
      diff = $signed(DIFF_W'(cen9)) - $signed(DIFF_W'(nsum));
      if (diff < 0) begin
         res = '0;
      end else if (diff > DIFF_W'(PIX_MAX)) begin
         res = RGB_W'(PIX_MAX);
      end else begin
         res = diff[RGB_W-1:0];
      end
      return res;
   endfunction

   // room in the result queue counts the beat already in flight
   assign job_pop = !job_empty
                    && ({1'b0, rsp_level} + (LVL_W + 1)'(b1_valid_ff)
                        < (LVL_W + 1)'(RSP_DEPTH));

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         nsum_in[k] = '0;
         for (int i = 0; i < WIN_N; i++) begin
            if (i != CENTRE) begin
               nsum_in[k] = nsum_in[k] + NSUM_W'(chan_of(job_data.win[i], k));
            end
         end
         cen9_in[k] = CEN9_W'({chan_of(job_data.win[CENTRE], k), 3'b000})
                      + CEN9_W'(chan_of(job_data.win[CENTRE], k));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= job_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         for (int k = 0; k < 3; k++) begin
            nsum_ff[k] <= nsum_in[k];
            cen9_ff[k] <= cen9_in[k];
         end
         b1_row_ff  <= job_data.row;
         b1_col_ff  <= job_data.col;
         b1_done_ff <= job_data.done;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sharp[k] = clamp(cen9_ff[k], nsum_ff[k]);
      end
      rsp_push             = b1_valid_ff;
      rsp_data.sharp_red   = sharp[0];
      rsp_data.sharp_green = sharp[1];
      rsp_data.sharp_blue  = sharp[2];
      rsp_data.out_row     = b1_row_ff;
      rsp_data.out_col     = b1_col_ff;
      rsp_data.frame_done  = b1_done_ff;
   end

   // last interior pixel of a square image sits on the diagonal
   `SHRP_ASSERT_IMPLY(a_done_diag, clock, reset, b1_valid_ff && b1_done_ff,
                      b1_row_ff == b1_col_ff, "frame end off the diagonal")

endmodule

[rtl/core/sharpen_3x3_rgb_filter.sv]
// Top level of the streaming 3x3 RGB sharpening filter.
//
//   channel   handshake          payload                 beat moves when
//   -------   ----------------   ---------------------   -----------------------
//   source    push / full        req_item (req_type)     push && !full
//   result    pop / empty        rsp_item (rsp_type)     pop && !empty
//   control   valid / ready      csr_image_dim (11 bit)  valid && ready
//
// One pixel per clock sustained while full is low; a result leaves the result
// queue once the beat completing its window has passed the line store read,
// window, sums and queue. The line store is a single-port-write, single-read
// memory of MAX_DIM words; its one read and one write per pixel set the rate.
// Reset is synchronous; the line store is not cleared and needs no sweep.
// full rises when the job queue cannot take the beats already in flight;
// the result side stalls only the back end, the front keeps going until
// the job queue fills.
module sharpen_3x3_rgb_filter #(
   parameter int MAX_DIM = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  shrp_pkg::req_type          req_item,
   output logic                       empty,
   input  logic                       pop,
   output shrp_pkg::rsp_type          rsp_item,
   input  logic                       valid,
   output logic                       ready,
   input  logic [shrp_pkg::DIM_W-1:0] csr_image_dim
);
   import shrp_pkg::*;

   logic [DIM_W-1:0] dim_ff;

   logic             job_push, job_pop, job_empty;
   job_type          job_wr, job_rd;
   logic [LVL_W-1:0] job_level;

   logic             rsp_push;
   rsp_type          rsp_wr;
   logic [LVL_W-1:0] rsp_level;

   // control register: always ready; write only while the block is idle, the block does not enforce it
   assign ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= DIM_W'(DIM_RESET);
      end else if (valid && ready) begin
         dim_ff <= csr_image_dim;
      end
   end

   // front: counters, line store, window; issues interior windows only
   shrp_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .image_dim (dim_ff),
      .job_level (job_level),
      .job_push  (job_push),
      .job_data  (job_wr)
   );

   // decouples the front from stalls on the result side
   shrp_fifo #(
      .WIDTH ($bits(job_type)),
      .DEPTH (JOB_DEPTH)
   ) u_job_q (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (job_push),
      .wr_data  (job_wr),
      .rd_pop   (job_pop),
      .rd_data  (job_rd),
      .rd_empty (job_empty),
      .level    (job_level)
   );

   // back: nine-times-centre minus neighbours, clamp to a byte
   shrp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_data  (job_rd),
      .job_pop   (job_pop),
      .rsp_level (rsp_level),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wr)
   );

   // result queue: the head is shown on rsp_item while empty is low
   shrp_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (rsp_push),
      .wr_data  (rsp_wr),
      .rd_pop   (pop && !empty),
      .rd_data  (rsp_item),
      .rd_empty (empty),
      .level    (rsp_level)
   );

endmodule

[test/sharpen_3x3_rgb_filter_tb.sv]
// Self-checking testbench for the streaming 3x3 RGB sharpening filter.
`timescale 1ns / 100ps

module sharpen_3x3_rgb_filter_tb;
   import shrp_pkg::*;

   localparam int MAX_SIDE    = 1024;     // matches the MAX_DIM the block is built with
   localparam int SETTLE      = 12;       // margin for pixels still in the pipeline
   localparam int HOLD_CYCLES = 120;      // long result hold, enough to back up the input
   localparam int CYCLE_LIMIT = 500000;
   localparam int SHOW_MAX    = 10;

   // Every input is known from time zero.
   logic             clock         = 1'b0;
   logic             reset         = 1'b1;
   logic             push          = 1'b0;
   logic             full;
   req_type          req_item      = '0;
   logic             empty;
   logic             pop           = 1'b0;
   rsp_type          rsp_item;
   logic             valid         = 1'b0;
   logic             ready;
   logic [DIM_W-1:0] csr_image_dim = '0;

   sharpen_3x3_rgb_filter #(.MAX_DIM(MAX_SIDE)) dut (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_item      (req_item),
      .empty         (empty),
      .pop           (pop),
      .rsp_item      (rsp_item),
      .valid         (valid),
      .ready         (ready),
      .csr_image_dim (csr_image_dim)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow of the filter: two line stores, the two previous window columns,
   // the raster position of the next pixel and the side length register.
   rgb_type          upper_line  [MAX_SIDE];
   rgb_type          middle_line [MAX_SIDE];
   rgb_type          window_px   [6];   // [row*2] = column c-2, [row*2+1] = column c-1
   logic [POS_W-1:0] row_pos     = '0;
   logic [POS_W-1:0] col_pos     = '0;
   logic [DIM_W-1:0] dim_setting = DIM_W'(DIM_RESET);

   rsp_type sharpened_due [$];   // sharpened pixels still to come out, oldest first
   req_type pixel_backlog [$];   // pixels waiting for the source driver

   int pixels_queued   = 0;
   int pixels_accepted = 0;
   int results_checked = 0;
   int mismatches      = 0;
   int dims_written    = 0;
   int cycle_count     = 0;
   int idle_pct        = 0;      // chance in a hundred that the source idles
   int stall_pct       = 0;      // chance in a hundred that the sink stalls
   int hold_asked      = 0;
   int hold_given      = 0;
   int hold_left       = 0;

   // Smooth patches keep most sharpened values off the clamps.
   bit      textured     = 1'b0;
   rgb_type texture_base = '0;

   // 9 * centre - eight neighbours, clamped; lane 2 red, 1 green, 0 blue.
   function automatic logic [RGB_W-1:0] sharpen_level(input rgb_type nb [9], input int lane);
      int acc;
      int v;
      acc = 0;
      for (int i = 0; i < WIN_N; i++) begin
         v = nb[i][RGB_W*lane +: RGB_W];
         acc += (i == CENTRE) ? 9 * v : -v;
      end
      if (acc < 0) acc = 0;
      if (acc > PIX_MAX) acc = PIX_MAX;
      return RGB_W'(acc);
   endfunction

   // One accepted pixel: maybe one sharpened result, then shift and advance.
   task automatic predict_pixel(input req_type px);
      int      side, r, c;
      rgb_type cur, top, mid;
      rgb_type nb [9];
      rsp_type res;
      side = (dim_setting < DIM_MIN) ? DIM_MIN :
             (dim_setting > MAX_SIDE) ? MAX_SIDE : int'(dim_setting);
      if (px.frame_start) begin
         row_pos = '0;
         col_pos = '0;
      end
      r   = row_pos;
      c   = col_pos;
      cur = '{px.pix_red, px.pix_green, px.pix_blue};
      top = upper_line[c];
      mid = middle_line[c];
      nb  = '{window_px[0], window_px[1], top,
              window_px[2], window_px[3], mid,
              window_px[4], window_px[5], cur};
      // Result belongs to (r-1, c-1); counters left beyond a shrunk side give none.
      if (r >= 2 && c >= 2 && r < side && c < side) begin
         res.sharp_red   = sharpen_level(nb, 2);
         res.sharp_green = sharpen_level(nb, 1);
         res.sharp_blue  = sharpen_level(nb, 0);
         res.out_row     = POS_W'(r - 1);
         res.out_col     = POS_W'(c - 1);
         res.frame_done  = (r == side - 1 && c == side - 1);
         sharpened_due.push_back(res);
      end
      window_px[0] = window_px[1];
      window_px[1] = top;
      window_px[2] = window_px[3];
      window_px[3] = mid;
      window_px[4] = window_px[5];
      window_px[5] = cur;
      upper_line[c]  = mid;
      middle_line[c] = cur;
      // Column wraps at the side, row wraps too, so frames may run back to back.
      if (c + 1 >= side) begin
         col_pos = '0;
         row_pos = (r + 1 >= side) ? '0 : POS_W'(r + 1);
      end else begin
         col_pos = POS_W'(c + 1);
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (sharpened_due.size() == 0) begin
         mismatches++;
         if (mismatches <= SHOW_MAX)
            $display("unexpected result: rgb %0d/%0d/%0d at (%0d,%0d) done %0b",
                     got.sharp_red, got.sharp_green, got.sharp_blue,
                     got.out_row, got.out_col, got.frame_done);
         return;
      end
      want = sharpened_due.pop_front();
      results_checked++;
      if (got.sharp_red !== want.sharp_red || got.sharp_green !== want.sharp_green ||
          got.sharp_blue !== want.sharp_blue || got.out_row !== want.out_row ||
          got.out_col !== want.out_col || got.frame_done !== want.frame_done) begin
         mismatches++;
         if (mismatches <= SHOW_MAX)
            $display("mismatch: expected rgb %0d/%0d/%0d at (%0d,%0d) done %0b, %s",
                     want.sharp_red, want.sharp_green, want.sharp_blue,
                     want.out_row, want.out_col, want.frame_done,
                     $sformatf("got rgb %0d/%0d/%0d at (%0d,%0d) done %0b",
                               got.sharp_red, got.sharp_green, got.sharp_blue,
                               got.out_row, got.out_col, got.frame_done));
      end
   endtask

   // Source driver. A refused beat stays on the bus unchanged; otherwise the
   // next pixel, if one waits, goes out unless the source decides to idle this cycle.
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            predict_pixel(req_item);
            pixels_accepted++;
         end
         if (!(push && full)) begin
            if (pixel_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_item <= pixel_backlog.pop_front();
               push     <= 1'b1;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // Result sink: checks each beat taken, stalls at random or during a hold.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) check_result(rsp_item);
         pop <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
      end
   end

   // Long sink hold, timed here so the source keeps pushing meanwhile.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_given != hold_asked) begin
         hold_left  <= HOLD_CYCLES;
         hold_given <= hold_given + 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sharpen_3x3_rgb_filter regression: fail");
         $finish;
      end
   end

   // Wait for every pixel to be taken and every result to be checked, then let
   // the pipeline run dry: pixels that give no result may still be in flight.
   task automatic settle_all();
      while (pixels_accepted != pixels_queued || sharpened_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // Only called with the block idle.
   task automatic write_image_dim(input logic [DIM_W-1:0] side);
      @(posedge clock);
      valid         <= 1'b1;
      csr_image_dim <= side;
      do @(posedge clock); while (!ready);
      valid       <= 1'b0;
      dim_setting  = side;
      dims_written++;
      @(negedge clock);
   endtask

   task automatic queue_pixel(input rgb_type px, input bit start);
      req_type item;
      item.pix_red     = px.red;
      item.pix_green   = px.green;
      item.pix_blue    = px.blue;
      item.frame_start = start;
      pixel_backlog.push_back(item);
      pixels_queued++;
   endtask

   function automatic rgb_type random_pixel();
      rgb_type px;
      if (textured) begin
         px.red   = texture_base.red   + RGB_W'($urandom_range(12));
         px.green = texture_base.green + RGB_W'($urandom_range(12));
         px.blue  = texture_base.blue  + RGB_W'($urandom_range(12));
      end else begin
         px = 24'($urandom);
      end
      return px;
   endfunction

   // 3x3 frame: one value all round, another in the centre.
   task automatic queue_frame(input rgb_type ring, input rgb_type centre, input bit start);
      for (int i = 0; i < WIN_N; i++)
         queue_pixel((i == CENTRE) ? centre : ring, start && i == 0);
   endtask

   // Mostly whole frames in raster order; now and then a restart mid-frame.
   task automatic queue_stream(input int count, input bit restart);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(49) == 0) textured = !textured;
         if ($urandom_range(29) == 0)
            texture_base = '{RGB_W'($urandom_range(243)), RGB_W'($urandom_range(243)),
                             RGB_W'($urandom_range(243))};
         queue_pixel(random_pixel(), (i == 0 && restart) || $urandom_range(79) == 0);
      end
   endtask

   // Without a restart the new side takes effect mid-frame.
   task automatic run_phase(input int count, input logic [DIM_W-1:0] side,
                            input int send_idle, input int recv_stall,
                            input bit restart, input bit squeeze);
      settle_all();
      write_image_dim(side);
      idle_pct  = send_idle;
      stall_pct = recv_stall;
      if (squeeze) begin
         // Sink holds off while the source keeps going, so the block backs up;
         // then the source stops until the last result is in.
         hold_asked++;
         queue_stream(count / 2, restart);
         settle_all();
         queue_stream(count - count / 2, 1'b0);
      end else begin
         queue_stream(count, restart);
      end
   endtask

   initial begin
      int side;
      foreach (window_px[i]) window_px[i] = '0;
      foreach (upper_line[i]) begin
         upper_line[i]  = '0;
         middle_line[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Side is 512 out of reset: the first rows give nothing.
      for (int i = 0; i < 5; i++) queue_pixel(random_pixel(), i == 0);
      settle_all();

      // Smallest side, by hand: clamp at zero, clamp at full scale with
      // per-channel spread, a restart mid-frame, exact arithmetic.
      write_image_dim(DIM_W'(DIM_MIN));
      queue_frame('{8'd255, 8'd255, 8'd255}, '{8'd0, 8'd0, 8'd0}, 1'b1);
      queue_frame('{8'd0, 8'd0, 8'd1}, '{8'd255, 8'd28, 8'd0}, 1'b0);
      queue_pixel('{8'h5a, 8'ha5, 8'h0f}, 1'b0);
      queue_frame('{8'd100, 8'd31, 8'd200}, '{8'd120, 8'd30, 8'd201}, 1'b1);

      // Wide frame: past its second row every line store entry below column 40
      // is written, so resizing mid-frame to any side used below is safe.
      textured = 1'b1;
      texture_base = '{8'd60, 8'd130, 8'd200};
      run_phase(180, DIM_W'(40), 0, 0, 1'b1, 1'b0);
      // 2047 clamps to the largest side; a fresh first row gives nothing.
      run_phase(40, DIM_W'(2047), 25, 25, 1'b1, 1'b0);

      // Sides below the minimum, entered mid-frame with the counters far out.
      run_phase(30, DIM_W'(0), 0, 0, 1'b0, 1'b0);
      run_phase(30, DIM_W'(1), 71, 0, 1'b0, 1'b0);
      run_phase(30, DIM_W'(2), 0, 71, 1'b0, 1'b0);

      run_phase(300, DIM_W'(4), 0, 30, 1'b1, 1'b1);

      // Random bulk across the four idling patterns, mostly small sides.
      for (int p = 0; p < 10; p++) begin
         side = ($urandom_range(4) == 0) ? 33 : DIM_MIN + $urandom_range(9);
         run_phase(120, DIM_W'(side),
                   (p % 4 == 1) ? 71 : (p % 4 == 3) ? 25 : 0,
                   (p % 4 == 2) ? 71 : (p % 4 == 3) ? 25 : 0,
                   bit'($urandom_range(1)), 1'b0);
      end
      settle_all();

      $display("%0d pixels in, %0d sharpened beats checked, %0d side length writes",
               pixels_accepted, results_checked, dims_written);
      $display("sides 3 to 40 with results, out-of-range sides clamped, restarts and");
      $display("resizes mid-frame, idling and a long hold");
      if (mismatches == 0) begin
         $display("sharpen_3x3_rgb_filter regression: pass");
      end else begin
         $display("sharpen_3x3_rgb_filter regression: fail");
      end
      $finish;
   end

endmodule
